[src/whp_pkg.sv]
// Shared types and constants for the WAV header parser.
// No dependencies; imported by the controller, the datapath and the top level.
package whp_pkg;

  localparam int unsigned OFF_W    = 6;
  localparam int unsigned HDR_LEN  = 36;
  localparam int unsigned LAST_OFF = HDR_LEN - 1;
  localparam int unsigned OUT_W    = 200;

  // Magic words, lowest byte first as they appear in the file
  localparam logic [31:0] RIFF_WORD = 32'h4646_4952;  // "RIFF"
  localparam logic [31:0] WAVE_WORD = 32'h4556_4157;  // "WAVE"

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_MAGIC = 2'd1,
    STAT_RATE  = 2'd2
  } status_t;

  // Controller to datapath
  typedef struct packed {
    logic take_byte;
    logic mul_align;
    logic mul_rate;
    logic judge;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic hdr_done;
  } dp_stat_t;

endpackage

[src/wav_header_parser_top.sv]
// Top level of the WAV header parser: controller plus datapath.
// Depends on whp_pkg, whp_ctrl and whp_datapath.
//
//  channel | dir | ports                         | word
//  in      | in  | in_tvalid/tready/tdata/tuser  | one file byte, tuser = start of file
//  out     | out | out_tvalid/tready/tdata       | full header fields and status
//
// One byte is taken per cycle. After the byte at offset 35 the input stalls through
// the check steps (channels x bits, then sample rate x that product on the 32x32
// multiplier, then the compare) and until the result word is taken.
// Bytes past offset 35 are taken and dropped. Reset is synchronous, active low,
// and returns the parser to offset zero.
module wav_header_parser_top
  import whp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,   // [7:0] data_byte
  input  logic             in_tuser,   // [0] start_of_file
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata   // status, riff_size, fmt_size, audio_format,
                                       // channels, sample_rate, byte_rate,
                                       // block_align, bits_per_sample, zero pad
);

  dp_cmd_t     cmd;
  dp_stat_t    stat;
  logic [1:0]  status;
  logic [31:0] riff_size, fmt_size, sample_rate, byte_rate;
  logic [15:0] audio_format, channels, block_align, bits_per_sample;

  whp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid)
  );

  whp_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .data_byte       (in_tdata),
    .start_of_file   (in_tuser),
    .stat            (stat),
    .status          (status),
    .riff_size       (riff_size),
    .fmt_size        (fmt_size),
    .audio_format    (audio_format),
    .channels        (channels),
    .sample_rate     (sample_rate),
    .byte_rate       (byte_rate),
    .block_align     (block_align),
    .bits_per_sample (bits_per_sample)
  );

  assign out_tdata = {6'b0, bits_per_sample, block_align, byte_rate, sample_rate,
                      channels, audio_format, fmt_size, riff_size, status};

endmodule

[src/whp_ctrl.sv]
// Sequencer for the WAV header parser: byte intake, check steps, result hand-off.
// Depends on whp_pkg.
module whp_ctrl
  import whp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  input  logic     out_tready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd,
  output logic     in_tready,
  output logic     out_tvalid
);

  typedef enum logic [2:0] {
    ST_RUN,
    ST_MUL1,
    ST_MUL2,
    ST_CMP,
    ST_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_tready_r, in_tready_nxt;
  logic   out_tvalid_r, out_tvalid_nxt;

  always_comb begin
    state_nxt      = state_r;
    in_tready_nxt  = in_tready_r;
    out_tvalid_nxt = out_tvalid_r;
    case (state_r)
      ST_RUN: begin
        if (in_tvalid && in_tready_r && stat.hdr_done) begin
          state_nxt     = ST_MUL1;
          in_tready_nxt = 1'b0;
        end
      end
      ST_MUL1: state_nxt = ST_MUL2;
      ST_MUL2: state_nxt = ST_CMP;
      ST_CMP: begin
        state_nxt      = ST_OUT;
        out_tvalid_nxt = 1'b1;
      end
      ST_OUT: begin
        if (out_tready) begin
          state_nxt      = ST_RUN;
          out_tvalid_nxt = 1'b0;
          in_tready_nxt  = 1'b1;
        end
      end
      default: begin
        state_nxt      = ST_RUN;
        in_tready_nxt  = 1'b1;
        out_tvalid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_RUN;
      in_tready_r  <= 1'b1;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      in_tready_r  <= in_tready_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  assign cmd.take_byte = in_tvalid && in_tready_r;
  assign cmd.mul_align = (state_r == ST_MUL1);
  assign cmd.mul_rate  = (state_r == ST_MUL2);
  assign cmd.judge     = (state_r == ST_CMP);
  assign in_tready     = in_tready_r;
  assign out_tvalid    = out_tvalid_r;

endmodule

[src/whp_datapath.sv]
// Datapath of the WAV header parser: offset counter, field assembly,
// magic check and the two-step product check. Depends on whp_pkg.
module whp_datapath
  import whp_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  dp_cmd_t      cmd,
  input  logic [7:0]   data_byte,
  input  logic         start_of_file,
  output dp_stat_t     stat,
  output logic [1:0]   status,
  output logic [31:0]  riff_size,
  output logic [31:0]  fmt_size,
  output logic [15:0]  audio_format,
  output logic [15:0]  channels,
  output logic [31:0]  sample_rate,
  output logic [31:0]  byte_rate,
  output logic [15:0]  block_align,
  output logic [15:0]  bits_per_sample
);

  logic [OFF_W-1:0] offset_r;
  logic [OFF_W-1:0] off;
  logic             magic_bad_r;
  logic [31:0]      riff_r, fmt_r, rate_r, brate_r;
  logic [15:0]      format_r, chan_r, align_r, bps_r;
  logic [31:0]      prod_a_r;
  logic [63:0]      prod_b_r;
  status_t          status_r;
  logic [7:0]       want_byte;
  logic             miss;

  assign off = start_of_file ? '0 : offset_r;

  always_comb begin
    if (off < OFF_W'(4)) begin
      want_byte = RIFF_WORD[{off[1:0], 3'b000} +: 8];
    end else begin
      want_byte = WAVE_WORD[{off[1:0], 3'b000} +: 8];
    end
  end
  assign miss = (data_byte != want_byte);

  assign stat.hdr_done = (off == OFF_W'(LAST_OFF));

  // Offset and magic flag are control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r    <= '0;
      magic_bad_r <= 1'b0;
    end else if (cmd.take_byte) begin
      if (off < OFF_W'(HDR_LEN)) begin
        offset_r <= off + OFF_W'(1);
      end else begin
        offset_r <= off;
      end
      if (off == '0) begin
        magic_bad_r <= miss;
      end else if ((off < OFF_W'(4)) || ((off >= OFF_W'(8)) && (off < OFF_W'(12)))) begin
        magic_bad_r <= magic_bad_r | miss;
      end
    end
  end

  // Shift each little-endian field in, lowest byte first
  always_ff @(posedge clk) begin
    if (cmd.take_byte) begin
      if (off >= OFF_W'(4) && off < OFF_W'(8))   riff_r   <= {data_byte, riff_r[31:8]};
      if (off >= OFF_W'(16) && off < OFF_W'(20)) fmt_r    <= {data_byte, fmt_r[31:8]};
      if (off >= OFF_W'(20) && off < OFF_W'(22)) format_r <= {data_byte, format_r[15:8]};
      if (off >= OFF_W'(22) && off < OFF_W'(24)) chan_r   <= {data_byte, chan_r[15:8]};
      if (off >= OFF_W'(24) && off < OFF_W'(28)) rate_r   <= {data_byte, rate_r[31:8]};
      if (off >= OFF_W'(28) && off < OFF_W'(32)) brate_r  <= {data_byte, brate_r[31:8]};
      if (off >= OFF_W'(32) && off < OFF_W'(34)) align_r  <= {data_byte, align_r[15:8]};
      if (off >= OFF_W'(34) && off < OFF_W'(36)) bps_r    <= {data_byte, bps_r[15:8]};
    end
    if (cmd.mul_align) begin
      prod_a_r <= {16'b0, chan_r} * {16'b0, bps_r};
    end
    if (cmd.mul_rate) begin
      prod_b_r <= {32'b0, rate_r} * {32'b0, prod_a_r};
    end
    if (cmd.judge) begin
      if (magic_bad_r) begin
        status_r <= STAT_MAGIC;
      end else if ((prod_a_r[31:3] != {13'b0, align_r}) ||
                   (prod_b_r[63:3] != {29'b0, brate_r})) begin
        status_r <= STAT_RATE;
      end else begin
        status_r <= STAT_OK;
      end
    end
  end

  // Fields hold while the result waits: no byte is taken then
  assign status          = status_r;
  assign riff_size       = riff_r;
  assign fmt_size        = fmt_r;
  assign audio_format    = format_r;
  assign channels        = chan_r;
  assign sample_rate     = rate_r;
  assign byte_rate       = brate_r;
  assign block_align     = align_r;
  assign bits_per_sample = bps_r;

endmodule

[verif/whp_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for the WAV header parser: mirrors the byte-by-byte parse and checks result words.
// Depends on whp_pkg; instantiated beside the parser in the testbench top.
module whp_checker
  import whp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_tready,
  input  logic [7:0]       in_tdata,
  input  logic             in_tuser,
  input  logic             out_tvalid,
  input  logic             out_tready,
  input  logic [OUT_W-1:0] out_tdata,
  output int               fail_count,
  output int               pending,
  output int               n_ok,
  output int               n_magic,
  output int               n_rate
);

  // Laid out so that it matches out_tdata from bit 0 upwards
  typedef struct packed {
    logic [15:0] bits_per_sample;
    logic [15:0] block_align;
    logic [31:0] byte_rate;
    logic [31:0] sample_rate;
    logic [15:0] channels;
    logic [15:0] audio_format;
    logic [31:0] fmt_size;
    logic [31:0] riff_size;
    status_t     status;
  } wav_result_t;

  localparam int unsigned RES_W = $bits(wav_result_t);

  wav_result_t headers_due[$];

  logic [OFF_W-1:0] offset;
  logic             magic_bad;
  logic [31:0]      riff_acc, fmt_size_acc, rate_acc, byte_rate_acc;
  logic [15:0]      format_acc, channels_acc, align_acc;
  logic [7:0]       bps_low;
  int               errors, cnt_ok, cnt_magic, cnt_rate;

  task automatic parse_byte(input logic [7:0] b, input logic sof);
    int unsigned  off;
    logic         miss;
    logic [15:0]  bps;
    logic [31:0]  frame_bits;
    logic [63:0]  want_rate;
    wav_result_t  r;
    off = sof ? 0 : offset;
    if (off < 4) begin
      miss = (b != RIFF_WORD[8*off +: 8]);
      magic_bad = (off == 0) ? miss : (magic_bad | miss);
    end else if (off < 8) begin
      riff_acc = {b, riff_acc[31:8]};
    end else if (off < 12) begin
      if (b != WAVE_WORD[8*(off-8) +: 8]) magic_bad = 1'b1;
    end else if (off < 16) begin
      // fmt identifier: not checked
    end else if (off < 20) begin
      fmt_size_acc = {b, fmt_size_acc[31:8]};
    end else if (off < 22) begin
      format_acc = {b, format_acc[15:8]};
    end else if (off < 24) begin
      channels_acc = {b, channels_acc[15:8]};
    end else if (off < 28) begin
      rate_acc = {b, rate_acc[31:8]};
    end else if (off < 32) begin
      byte_rate_acc = {b, byte_rate_acc[31:8]};
    end else if (off < 34) begin
      align_acc = {b, align_acc[15:8]};
    end else if (off == 34) begin
      bps_low = b;
    end else if (off == LAST_OFF) begin
      bps        = {b, bps_low};
      frame_bits = 32'(channels_acc) * 32'(bps);
      want_rate  = (64'(rate_acc) * 64'(frame_bits)) >> 3;
      if (magic_bad)
        r.status = STAT_MAGIC;
      else if ((frame_bits >> 3) != 32'(align_acc) || want_rate != 64'(byte_rate_acc))
        r.status = STAT_RATE;
      else
        r.status = STAT_OK;
      r.riff_size       = riff_acc;
      r.fmt_size        = fmt_size_acc;
      r.audio_format    = format_acc;
      r.channels        = channels_acc;
      r.sample_rate     = rate_acc;
      r.byte_rate       = byte_rate_acc;
      r.block_align     = align_acc;
      r.bits_per_sample = bps;
      headers_due.push_back(r);
    end
    // saturate at the header length: trailing bytes are dropped
    if (off < HDR_LEN) offset = OFF_W'(off + 1);
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t %s: expected %0h actual %0h", $time, name, want, got);
    end
  endfunction

  task automatic check_result(input logic [OUT_W-1:0] word);
    wav_result_t w, g;
    if (headers_due.size() == 0) begin
      errors++;
      $display("%0t result: expected none actual %0h", $time, word);
      return;
    end
    w = headers_due.pop_front();
    g = wav_result_t'(word[RES_W-1:0]);
    check_field("status", 32'(w.status), 32'(g.status));
    check_field("riff_size", w.riff_size, g.riff_size);
    check_field("fmt_size", w.fmt_size, g.fmt_size);
    check_field("audio_format", 32'(w.audio_format), 32'(g.audio_format));
    check_field("channels", 32'(w.channels), 32'(g.channels));
    check_field("sample_rate", w.sample_rate, g.sample_rate);
    check_field("byte_rate", w.byte_rate, g.byte_rate);
    check_field("block_align", 32'(w.block_align), 32'(g.block_align));
    check_field("bits_per_sample", 32'(w.bits_per_sample), 32'(g.bits_per_sample));
    check_field("pad", 32'd0, 32'(word[OUT_W-1:RES_W]));
    case (w.status)
      STAT_OK:    cnt_ok++;
      STAT_MAGIC: cnt_magic++;
      default:    cnt_rate++;
    endcase
  endtask

  initial begin
    errors = 0;
    cnt_ok = 0;
    cnt_magic = 0;
    cnt_rate = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      offset        = '0;
      magic_bad     = 1'b0;
      riff_acc      = '0;
      fmt_size_acc  = '0;
      format_acc    = '0;
      channels_acc  = '0;
      rate_acc      = '0;
      byte_rate_acc = '0;
      align_acc     = '0;
      bps_low       = '0;
      headers_due.delete();
    end else begin
      if (in_tvalid && in_tready) parse_byte(in_tdata, in_tuser);
      if (out_tvalid && out_tready) check_result(out_tdata);
    end
    fail_count <= errors;
    pending    <= headers_due.size();
    n_ok       <= cnt_ok;
    n_magic    <= cnt_magic;
    n_rate     <= cnt_rate;
  end

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps
// Testbench top for the WAV header parser: clock, reset, header and noise stimulus, verdict.
// Depends on whp_pkg, wav_header_parser_top and whp_checker.
module testbench
  import whp_pkg::*;
;

  localparam int TARGET_BYTES   = 2000;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 10;

  typedef struct packed {
    logic [31:0] riff_size;
    logic [31:0] fmt_size;
    logic [15:0] audio_format;
    logic [15:0] channels;
    logic [31:0] sample_rate;
    logic [31:0] byte_rate;
    logic [15:0] block_align;
    logic [15:0] bits_per_sample;
  } wav_fmt_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [7:0]       in_tdata = '0;
  logic             in_tuser = 1'b0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic             steady = 1'b0;
  int               fail_count, pending, n_ok, n_magic, n_rate;
  int               bytes_sent = 0;
  int               idle_cycles = 0;

  wav_header_parser_top u_dut (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata
  );

  whp_checker u_checker (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata,
    .fail_count, .pending, .n_ok, .n_magic, .n_rate
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(99) >= 7);
  end

  // Watchdog: end the run once no word has moved on either side for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic sof);
    while (!steady && $urandom_range(99) < 7) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= sof;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
    // hold the no-idle stretch over the middle of the run
    steady <= (bytes_sent >= 900 && bytes_sent < 1300);
  endtask

  task automatic send_noise(input int n);
    for (int i = 0; i < n; i++) send_byte(8'($urandom), $urandom_range(7) == 0);
  endtask

  // Send the first cut bytes of a header, then tail trailing bytes
  task automatic send_header(input wav_fmt_t h, input logic [31:0] riff, input logic [31:0] wave,
                             input logic sof, input int cut, input int tail);
    logic [HDR_LEN*8-1:0] image;
    image = {h.bits_per_sample, h.block_align, h.byte_rate, h.sample_rate, h.channels,
             h.audio_format, h.fmt_size, 32'($urandom), wave, h.riff_size, riff};
    for (int i = 0; i < cut; i++) send_byte(image[8*i +: 8], sof && i == 0);
    for (int i = 0; i < tail; i++) send_byte(8'($urandom), 1'b0);
  endtask

  // Mostly plausible PCM headers; align and byte rate follow the other fields
  function automatic wav_fmt_t make_pcm();
    wav_fmt_t   h;
    logic [31:0] frame_bits;
    h.riff_size    = $urandom;
    h.fmt_size     = ($urandom_range(3) == 0) ? $urandom : 32'd16;
    h.audio_format = ($urandom_range(3) == 0) ? 16'($urandom) : 16'd1;
    h.channels     = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 8));
    case ($urandom_range(4))
      0:       h.bits_per_sample = 16'd8;
      1:       h.bits_per_sample = 16'd16;
      2:       h.bits_per_sample = 16'd24;
      3:       h.bits_per_sample = 16'd32;
      default: h.bits_per_sample = 16'($urandom);
    endcase
    h.sample_rate = ($urandom_range(4) == 0) ? $urandom : $urandom_range(8000, 192000);
    frame_bits    = 32'(h.channels) * 32'(h.bits_per_sample);
    h.block_align = 16'(frame_bits >> 3);
    h.byte_rate   = 32'((64'(h.sample_rate) * 64'(frame_bits)) >> 3);
    return h;
  endfunction

  initial begin
    wav_fmt_t    h;
    logic [31:0] riff, wave;
    int          pick, cut, flip;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: first header without a start flag after reset
    h = '{riff_size: 32'd1036, fmt_size: 32'd16, audio_format: 16'd1, channels: 16'd2,
          sample_rate: 32'd44100, byte_rate: 32'd176400, block_align: 16'd4,
          bits_per_sample: 16'd16};
    send_header(h, RIFF_WORD, WAVE_WORD, 1'b0, HDR_LEN, 4);
    // all fields zero: consistent
    send_header('0, RIFF_WORD, WAVE_WORD, 1'b1, HDR_LEN, 0);
    // widest fields that still agree
    h = '{riff_size: '1, fmt_size: '1, audio_format: '1, channels: 16'd1,
          sample_rate: '1, byte_rate: '1, block_align: 16'd1, bits_per_sample: 16'd8};
    send_header(h, RIFF_WORD, WAVE_WORD, 1'b1, HDR_LEN, 2);
    // all ones: products overflow the fields
    send_header('1, RIFF_WORD, WAVE_WORD, 1'b1, HDR_LEN, 0);
    // bad RIFF, bad WAVE, then bad magic together with disagreeing sizes
    h = make_pcm();
    send_header(h, RIFF_WORD ^ 32'h0000_0001, WAVE_WORD, 1'b1, HDR_LEN, 0);
    send_header(h, RIFF_WORD, WAVE_WORD ^ 32'h8000_0000, 1'b1, HDR_LEN, 0);
    h.block_align = h.block_align + 16'd1;
    send_header(h, RIFF_WORD ^ 32'h0100_0000, WAVE_WORD, 1'b1, HDR_LEN, 0);
    // align off by one, then byte rate off by one
    send_header(h, RIFF_WORD, WAVE_WORD, 1'b1, HDR_LEN, 0);
    h = make_pcm();
    h.byte_rate = h.byte_rate ^ 32'h1;
    send_header(h, RIFF_WORD, WAVE_WORD, 1'b1, HDR_LEN, 3);
    // restart in the middle of a header
    send_header(make_pcm(), RIFF_WORD, WAVE_WORD, 1'b1, 20, 0);
    send_header(make_pcm(), RIFF_WORD, WAVE_WORD, 1'b1, HDR_LEN, 1);

    while (bytes_sent < TARGET_BYTES) begin
      pick = $urandom_range(99);
      h    = make_pcm();
      riff = RIFF_WORD;
      wave = WAVE_WORD;
      cut  = HDR_LEN;
      if (pick < 10) begin
        h.block_align = 16'($urandom);
        h.byte_rate   = $urandom;
      end else if (pick < 18) begin
        flip = $urandom_range(63);
        if (flip < 32) riff = riff ^ (32'h1 << flip);
        else wave = wave ^ (32'h1 << (flip - 32));
      end else if (pick < 25) begin
        cut = $urandom_range(1, HDR_LEN - 1);
      end else if (pick < 30) begin
        send_noise($urandom_range(1, 50));
        continue;
      end
      send_header(h, riff, wave, $urandom_range(9) != 0, cut, $urandom_range(0, 6));
    end
    in_tvalid <= 1'b0;
    // let the checker's count catch up with the last byte taken
    @(posedge clk);

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d file bytes, including cut headers, restarts and trailing noise.",
             bytes_sent);
    $display("Headers checked: %0d consistent, %0d bad magic, %0d rate or align mismatch.",
             n_ok, n_magic, n_rate);
    if (fail_count == 0 && pending == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

[sim.f]
src/whp_pkg.sv
src/whp_ctrl.sv
src/whp_datapath.sv
src/wav_header_parser_top.sv
verif/whp_checker.sv
verif/testbench.sv
